[sv/fik_pkg.sv]
package fik_pkg;

  localparam int COORD_W = 32;
  localparam int JIDX_W  = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0]                status_t;

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // solve status codes
  localparam status_t STAT_CONVERGED = 2'd0;
  localparam status_t STAT_EXHAUSTED = 2'd1;
  localparam status_t STAT_STRETCHED = 2'd2;
  localparam status_t STAT_SHORT     = 2'd3;

  // register indexes on the apb port
  localparam logic REG_MAX_ITER = 1'b0;
  localparam logic REG_TOL      = 1'b1;

  localparam logic [7:0]  MAX_ITER_RST = 8'd10;
  localparam logic [15:0] TOL_RST      = 16'd7;

endpackage

[sv/fik_if.sv]
interface fik_item_if;
  import fik_pkg::*;
  logic   valid;
  logic   ready;
  logic   cmd;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   final_joint;
  modport source(output valid, cmd, pos_x, pos_y, pos_z, final_joint, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, final_joint, output ready);
endinterface

interface fik_result_if;
  import fik_pkg::*;
  logic              valid;
  logic              ready;
  logic [JIDX_W-1:0] joint_index;
  coord_t            out_x;
  coord_t            out_y;
  coord_t            out_z;
  status_t           status;
  logic              last;
  modport source(output valid, joint_index, out_x, out_y, out_z, status, last, input ready);
  modport sink(input valid, joint_index, out_x, out_y, out_z, status, last, output ready);
endinterface

[sv/fabrik_ik_chain_solver.sv]
// fabrik inverse kinematics solver for a 3d joint chain, signed q16.16 coordinates
//
// item channel: cmd 0 loads one joint; the item with final_joint set closes the
//   chain. segment lengths are computed while loading. joints past MAX_JOINTS
//   are dropped. cmd 1 carries a target and starts a solve.
// result channel: after a solve every joint comes out in order, root first,
//   with the run's status; last marks the final joint.
// apb port: register 0 max_iterations at byte 0, register 1 tolerance at byte 4.
// datapath: one shared 32x32 multiplier, a one bit per cycle square root and a
//   one bit per cycle divider. a load measures one segment; a solve places
//   joints - 1 joints per pass, runs a backward and a forward pass per
//   iteration and checks convergence after each pass pair.
// ready is high only while idle. the last result sits in an output register,
//   so the next item can be taken while it waits; a stalled receiver holds
//   the solver in its emit loop.
// reset (synchronous) empties the chain, reopens loading and sets the
//   registers to 10 and 7. the joint stores are not cleared.
module fabrik_ik_chain_solver #(
  parameter int MAX_JOINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  fik_item_if.sink    item,
  fik_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fik_pkg::*;

  localparam int IW = $clog2(MAX_JOINTS);
  localparam int JW = $clog2(MAX_JOINTS + 1);
  localparam int TW = 32 + IW;
  localparam int CW = (TW > 34) ? TW : 34;

  // sequencer states
  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_LD0     = 6'd1;
  localparam logic [5:0] S_LD_RD   = 6'd2;
  localparam logic [5:0] S_LD_CAP  = 6'd3;
  localparam logic [5:0] S_LD_SEG  = 6'd4;
  localparam logic [5:0] S_SV0     = 6'd5;
  localparam logic [5:0] S_SV1     = 6'd6;
  localparam logic [5:0] S_SV_TR   = 6'd7;
  localparam logic [5:0] S_SV_TA   = 6'd8;
  localparam logic [5:0] S_SV_CHK  = 6'd9;
  localparam logic [5:0] S_SV_CMP  = 6'd10;
  localparam logic [5:0] S_ST_NEXT = 6'd11;
  localparam logic [5:0] S_IT_ST   = 6'd12;
  localparam logic [5:0] S_BK_NEXT = 6'd13;
  localparam logic [5:0] S_IT_ROOT = 6'd14;
  localparam logic [5:0] S_FW_NEXT = 6'd15;
  localparam logic [5:0] S_CV0     = 6'd16;
  localparam logic [5:0] S_CV1     = 6'd17;
  localparam logic [5:0] S_CV_CMP  = 6'd18;
  localparam logic [5:0] S_EM_RD   = 6'd19;
  localparam logic [5:0] S_EM_LD   = 6'd20;
  localparam logic [5:0] S_PL0     = 6'd21;
  localparam logic [5:0] S_PL1     = 6'd22;
  localparam logic [5:0] S_PL2     = 6'd23;
  localparam logic [5:0] S_PL_DIV  = 6'd24;
  localparam logic [5:0] S_PL_DV   = 6'd25;
  localparam logic [5:0] S_PL_I0   = 6'd26;
  localparam logic [5:0] S_PL_I1   = 6'd27;
  localparam logic [5:0] S_PL_I2   = 6'd28;
  localparam logic [5:0] S_PL_I3   = 6'd29;
  localparam logic [5:0] S_LN_SQ   = 6'd30;
  localparam logic [5:0] S_LN_RT   = 6'd31;

  // joint and segment stores
  coord_t      mem_x [MAX_JOINTS];
  coord_t      mem_y [MAX_JOINTS];
  coord_t      mem_z [MAX_JOINTS];
  logic [31:0] mem_s [MAX_JOINTS];
  coord_t      rd_x, rd_y, rd_z;
  logic [31:0] rd_s;

  logic [5:0]    state, pl_ret, ln_ret;
  logic [IW-1:0] idx;
  logic [JW-1:0] jc;
  logic          lopen;
  logic [7:0]    max_it, iter;
  logic [15:0]   tol;
  status_t       status;
  logic          pl_back, pl_tgt, fin;
  coord_t        px, py, pz, rx, ry, rz, ax, ay, az, bx, by, bz;
  logic [31:0]   seg;
  logic [33:0]   len;
  logic [TW-1:0] total;
  logic [63:0]   t, dv_num, p_lo, mul_p;
  logic [33:0]   dv_rem;
  logic [67:0]   sq_rad;
  logic [35:0]   sq_rem;
  logic [65:0]   rad;
  logic [40:0]   q;
  logic [6:0]    step;
  logic [1:0]    cnt;

  // output register
  logic              o_valid, o_last;
  logic [JIDX_W-1:0] o_idx;
  coord_t            o_x, o_y, o_z;
  status_t           o_stat;

  // combinational datapath
  logic [JW-1:0] n_eff;
  logic [IW-1:0] nm1, nm2, src, dst, raddr_j, waddr_j;
  logic [2:0]    we_j;
  coord_t        wd_x, wd_y, wd_z, a_sel, b_sel;
  logic [32:0]   d;
  logic [31:0]   m, mul_a, mul_b;
  logic [64:0]   qsum;
  logic [37:0]   sq_cur, sq_trial;
  logic [34:0]   dv_cur;
  logic          sq_ge, dv_ge, em_last, o_free, o_load, cfg_wr;
  logic [42:0]   res_w;
  coord_t        res;
  logic [31:0]   len_sat;

  assign n_eff  = lopen ? jc : '0;
  assign nm1    = IW'(jc - JW'(1));
  assign nm2    = IW'(jc - JW'(2));
  assign src    = pl_back ? idx + IW'(1) : idx;
  assign dst    = pl_back ? idx : idx + IW'(1);
  assign em_last = (JW'(idx) + JW'(1)) >= jc;
  assign o_free = !o_valid || result.ready;
  assign o_load = (state == S_EM_LD) && o_free;

  // per axis operand select, shared by the square and interpolate steps
  always_comb begin
    case (cnt)
      2'd0: begin a_sel = ax; b_sel = bx; end
      2'd1: begin a_sel = ay; b_sel = by; end
      default: begin a_sel = az; b_sel = bz; end
    endcase
  end
  assign d     = {b_sel[31], b_sel} - {a_sel[31], a_sel};
  assign m     = d[32] ? (~d[31:0] + 32'd1) : d[31:0];
  assign mul_a = m;
  assign mul_b = (state == S_PL_I0) ? t[31:0] : ((state == S_PL_I1) ? t[63:32] : m);

  // floor(|b-a| * t) >> 32 assembled from two partial products
  assign qsum = {1'b0, mul_p} + {33'd0, p_lo[63:32]};

  // root step: two radicand bits per cycle
  assign sq_cur   = {sq_rem, sq_rad[67:66]};
  assign sq_trial = {2'b00, len, 2'b01};
  assign sq_ge    = sq_cur >= sq_trial;

  // divide step: one quotient bit per cycle
  assign dv_cur = {dv_rem, dv_num[63]};
  assign dv_ge  = dv_cur >= {1'b0, len};

  always_comb begin
    res_w = d[32] ? ({{11{a_sel[31]}}, a_sel} - {2'b00, q})
                  : ({{11{a_sel[31]}}, a_sel} + {2'b00, q});
    if (!res_w[42] && (res_w[41:31] != 11'd0)) begin
      res = 32'sh7fff_ffff;
    end else if (res_w[42] && (res_w[41:31] != 11'h7ff)) begin
      res = 32'sh8000_0000;
    end else begin
      res = res_w[31:0];
    end
  end

  assign len_sat = (len[33:32] != 2'b00) ? 32'hffff_ffff : len[31:0];

  // store addressing
  always_comb begin
    case (state)
      S_PL0:   raddr_j = src;
      S_PL1:   raddr_j = dst;
      S_SV0:   raddr_j = '0;
      S_LD_RD: raddr_j = idx - IW'(1);
      S_CV0:   raddr_j = nm1;
      default: raddr_j = idx;
    endcase
  end

  always_comb begin
    we_j    = 3'b000;
    waddr_j = dst;
    wd_x    = res;
    wd_y    = res;
    wd_z    = res;
    case (state)
      S_LD0: begin
        if (n_eff < JW'(MAX_JOINTS)) begin
          we_j = 3'b111;
        end
        waddr_j = IW'(n_eff);
        wd_x = px; wd_y = py; wd_z = pz;
      end
      S_IT_ST: begin
        we_j = 3'b111; waddr_j = nm1;
        wd_x = px; wd_y = py; wd_z = pz;
      end
      S_IT_ROOT: begin
        we_j = 3'b111; waddr_j = '0;
        wd_x = rx; wd_y = ry; wd_z = rz;
      end
      S_PL_I3: begin
        we_j = 3'b001 << cnt;
      end
      default: begin
        we_j = 3'b000;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_j[0]) mem_x[waddr_j] <= wd_x;
    if (we_j[1]) mem_y[waddr_j] <= wd_y;
    if (we_j[2]) mem_z[waddr_j] <= wd_z;
    if (state == S_LD_SEG) mem_s[idx - IW'(1)] <= len_sat;
    rd_x <= mem_x[raddr_j];
    rd_y <= mem_y[raddr_j];
    rd_z <= mem_z[raddr_j];
    rd_s <= mem_s[idx];
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
  end

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_MAX_ITER: prdata = {24'd0, max_it};
      default:      prdata = {16'd0, tol};
    endcase
  end

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = o_valid;
  assign result.joint_index = o_idx;
  assign result.out_x       = o_x;
  assign result.out_y       = o_y;
  assign result.out_z       = o_z;
  assign result.status      = o_stat;
  assign result.last        = o_last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      jc      <= '0;
      lopen   <= 1'b0;
      max_it  <= MAX_ITER_RST;
      tol     <= TOL_RST;
      o_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_MAX_ITER) max_it <= pwdata[7:0];
        else tol <= pwdata[15:0];
      end
      // output register: refill wins over the drain of the old item
      if (o_load) o_valid <= 1'b1;
      else if (result.ready) o_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            px  <= item.pos_x;
            py  <= item.pos_y;
            pz  <= item.pos_z;
            fin <= item.final_joint;
            state <= (item.cmd == CMD_LOAD) ? S_LD0 : S_SV0;
          end
        end

        // load one joint
        S_LD0: begin
          lopen <= !fin;
          if (n_eff < JW'(MAX_JOINTS)) begin
            jc  <= n_eff + JW'(1);
            idx <= IW'(n_eff);
            state <= (n_eff != '0) ? S_LD_RD : S_IDLE;
          end else begin
            jc <= n_eff;
            state <= S_IDLE;
          end
        end
        S_LD_RD: state <= S_LD_CAP;
        S_LD_CAP: begin
          ax <= rd_x; ay <= rd_y; az <= rd_z;
          bx <= px;   by <= py;   bz <= pz;
          cnt <= 2'd0; ln_ret <= S_LD_SEG; state <= S_LN_SQ;
        end
        S_LD_SEG: state <= S_IDLE;

        // solve setup: root and total chain length
        S_SV0: begin
          lopen <= 1'b0;
          idx <= '0;
          if (jc < JW'(2)) begin
            status <= STAT_SHORT;
            state  <= S_EM_RD;
          end else begin
            state <= S_SV1;
          end
        end
        S_SV1: begin
          rx <= rd_x; ry <= rd_y; rz <= rd_z;
          total <= '0;
          state <= S_SV_TR;
        end
        S_SV_TR: state <= S_SV_TA;
        S_SV_TA: begin
          total <= total + TW'(rd_s);
          if (idx == nm2) begin
            state <= S_SV_CHK;
          end else begin
            idx <= idx + IW'(1);
            state <= S_SV_TR;
          end
        end
        S_SV_CHK: begin
          ax <= rx; ay <= ry; az <= rz;
          bx <= px; by <= py; bz <= pz;
          cnt <= 2'd0; ln_ret <= S_SV_CMP; state <= S_LN_SQ;
        end
        S_SV_CMP: begin
          iter <= 8'd0;
          idx  <= '0;
          if (CW'(len) >= CW'(total)) begin
            // unreachable: lay the chain straight toward the target
            status <= STAT_STRETCHED;
            pl_back <= 1'b0; pl_tgt <= 1'b1; pl_ret <= S_ST_NEXT;
            state <= S_PL0;
          end else begin
            status <= STAT_EXHAUSTED;
            state <= (max_it == 8'd0) ? S_EM_RD : S_IT_ST;
          end
        end
        S_ST_NEXT: begin
          if (idx == nm2) begin
            idx <= '0; state <= S_EM_RD;
          end else begin
            idx <= idx + IW'(1); state <= S_PL0;
          end
        end

        // backward pass: end joint pinned to target
        S_IT_ST: begin
          idx <= nm2;
          pl_back <= 1'b1; pl_tgt <= 1'b0; pl_ret <= S_BK_NEXT;
          state <= S_PL0;
        end
        S_BK_NEXT: begin
          if (idx == '0) state <= S_IT_ROOT;
          else begin
            idx <= idx - IW'(1); state <= S_PL0;
          end
        end
        // forward pass: root pinned back
        S_IT_ROOT: begin
          idx <= '0;
          pl_back <= 1'b0; pl_tgt <= 1'b0; pl_ret <= S_FW_NEXT;
          state <= S_PL0;
        end
        S_FW_NEXT: begin
          if (idx == nm2) state <= S_CV0;
          else begin
            idx <= idx + IW'(1); state <= S_PL0;
          end
        end
        S_CV0: state <= S_CV1;
        S_CV1: begin
          ax <= px;   ay <= py;   az <= pz;
          bx <= rd_x; by <= rd_y; bz <= rd_z;
          cnt <= 2'd0; ln_ret <= S_CV_CMP; state <= S_LN_SQ;
        end
        S_CV_CMP: begin
          idx <= '0;
          if (len < {18'd0, tol}) begin
            status <= STAT_CONVERGED;
            state  <= S_EM_RD;
          end else if ({1'b0, iter} + 9'd1 == {1'b0, max_it}) begin
            state <= S_EM_RD;
          end else begin
            iter  <= iter + 8'd1;
            state <= S_IT_ST;
          end
        end

        // emit every joint through the output register
        S_EM_RD: state <= S_EM_LD;
        S_EM_LD: begin
          if (o_free) begin
            o_idx   <= JIDX_W'(idx);
            o_x     <= (jc == '0) ? '0 : rd_x;
            o_y     <= (jc == '0) ? '0 : rd_y;
            o_z     <= (jc == '0) ? '0 : rd_z;
            o_stat  <= status;
            o_last  <= em_last;
            if (em_last) state <= S_IDLE;
            else begin
              idx <= idx + IW'(1); state <= S_EM_RD;
            end
          end
        end

        // place one joint a segment length from src toward b
        S_PL0: state <= S_PL1;
        S_PL1: begin
          ax <= rd_x; ay <= rd_y; az <= rd_z;
          seg <= rd_s;
          state <= S_PL2;
        end
        S_PL2: begin
          bx <= pl_tgt ? px : rd_x;
          by <= pl_tgt ? py : rd_y;
          bz <= pl_tgt ? pz : rd_z;
          cnt <= 2'd0; ln_ret <= S_PL_DIV; state <= S_LN_SQ;
        end
        S_PL_DIV: begin
          t <= '0;
          cnt <= 2'd0;
          if (len == '0) state <= S_PL_I0;
          else begin
            dv_num <= {seg, 32'd0};
            dv_rem <= '0;
            step   <= '0;
            state  <= S_PL_DV;
          end
        end
        S_PL_DV: begin
          dv_num <= {dv_num[62:0], 1'b0};
          dv_rem <= dv_ge ? 34'(dv_cur - {1'b0, len}) : dv_cur[33:0];
          t      <= {t[62:0], dv_ge};
          step   <= step + 7'd1;
          if (step == 7'd63) state <= S_PL_I0;
        end
        S_PL_I0: state <= S_PL_I1;
        S_PL_I1: begin
          p_lo  <= mul_p;
          state <= S_PL_I2;
        end
        S_PL_I2: begin
          q <= (qsum > 65'h100_0000_0000) ? 41'h100_0000_0000 : qsum[40:0];
          state <= S_PL_I3;
        end
        S_PL_I3: begin
          if (cnt == 2'd2) state <= pl_ret;
          else begin
            cnt <= cnt + 2'd1; state <= S_PL_I0;
          end
        end

        // vector length: sum of squares, then bitwise square root
        S_LN_SQ: begin
          if (cnt == 2'd0) rad <= '0;
          else rad <= rad + 66'(mul_p);
          if (cnt == 2'd3) begin
            sq_rad <= {2'b00, rad + 66'(mul_p)};
            sq_rem <= '0;
            len    <= '0;
            step   <= '0;
            state  <= S_LN_RT;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        S_LN_RT: begin
          sq_rad <= {sq_rad[65:0], 2'b00};
          sq_rem <= sq_ge ? 36'(sq_cur - sq_trial) : sq_cur[35:0];
          len    <= {len[32:0], sq_ge};
          step   <= step + 7'd1;
          if (step == 7'd33) state <= ln_ret;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/fik_chk.sv]
module fik_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: accepting an item drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a new item is only taken once the run has reached its final result
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_last)
    else $error("item accepted in the middle of a result run");

endmodule

bind fabrik_ik_chain_solver fik_chk u_fik_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_last  (result.last)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fik_pkg::*;

  localparam int NJ_MAX     = 16;
  localparam int IDLE_PCT   = 36;
  localparam int HOLD_CYC   = 3000;
  localparam int WDOG_LIMIT = 600000;
  localparam int SETTLE_CYC = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fik_item_if   item();
  fik_result_if result();

  fabrik_ik_chain_solver #(.MAX_JOINTS(NJ_MAX)) dut (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one emitted joint
  typedef struct {
    logic [JIDX_W-1:0] idx;
    logic [31:0]       x, y, z;
    status_t           st;
    logic              lst;
  } joint_res_t;

  // directed stimulus row; typed rows carry their own single expected joint
  typedef struct {
    logic       cmd;
    int         x, y, z;
    logic       fin;
    bit         typed;
    int         ex, ey, ez;
    status_t    est;
  } stim_row_t;

  joint_res_t joints_due[$];

  // shadow of the solver: chain, segment lengths and registers
  longint          chain_x[NJ_MAX], chain_y[NJ_MAX], chain_z[NJ_MAX];
  logic [31:0]     seg_len[NJ_MAX];
  int unsigned     n_joints;
  bit              chain_open;
  logic [7:0]      iter_lim;
  logic [15:0]     tol_lim;

  int  mismatches = 0;
  bit  calm = 1'b0;       // no idling on either side
  bit  hold_req = 1'b0;   // receiver long hold-off request
  int  quiet_cyc = 0;

  // append one expected joint at the tail of the queue
  function automatic void due_add(joint_res_t r);
    joints_due.insert(joints_due.size(), r);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // floor of euclidean length, exact on wide integers
  function automatic logic [33:0] vec_len(longint dx, longint dy, longint dz);
    logic [127:0] acc;
    logic [33:0]  r, c;
    acc = 128'(abs64(dx)) * abs64(dx) + 128'(abs64(dy)) * abs64(dy)
        + 128'(abs64(dz)) * abs64(dz);
    r = '0;
    for (int k = 33; k >= 0; k--) begin
      c = r | (34'd1 << k);
      if (128'(c) * 128'(c) <= acc) r = c;
    end
    return r;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lerp_pt(longint a, longint b, logic [63:0] t);
    longint       d;
    logic [127:0] q;
    d = b - a;
    q = (128'(abs64(d)) * 128'(t)) >> 32;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return sat32((d < 0) ? a - longint'(q) : a + longint'(q));
  endfunction

  // move joint dst to sit one segment from src, heading for (tx,ty,tz)
  function automatic void place_joint(int dst, int src, longint tx, longint ty,
                                      longint tz, int s);
    logic [33:0] len;
    logic [63:0] t;
    longint      ax, ay, az;
    len = vec_len(tx - chain_x[src], ty - chain_y[src], tz - chain_z[src]);
    t   = (len == 0) ? 64'd0 : {seg_len[s], 32'd0} / 64'(len);
    ax = chain_x[src]; ay = chain_y[src]; az = chain_z[src];
    chain_x[dst] = lerp_pt(ax, tx, t);
    chain_y[dst] = lerp_pt(ay, ty, t);
    chain_z[dst] = lerp_pt(az, tz, t);
  endfunction

  // apply one accepted item and queue the joints it makes the block emit
  function automatic void solve_or_load(logic cmd, int ix, int iy, int iz, logic fin);
    longint      px, py, pz, rx, ry, rz;
    logic [33:0] l;
    longint      total;
    status_t     st;
    joint_res_t  r;
    int          n;
    px = ix; py = iy; pz = iz;
    if (cmd == CMD_LOAD) begin
      if (!chain_open) begin
        n_joints = 0;
        chain_open = 1'b1;
      end
      if (n_joints < NJ_MAX) begin
        n = n_joints;
        chain_x[n] = px; chain_y[n] = py; chain_z[n] = pz;
        if (n > 0) begin
          l = vec_len(px - chain_x[n-1], py - chain_y[n-1], pz - chain_z[n-1]);
          seg_len[n-1] = (l > 34'hFFFFFFFF) ? 32'hFFFFFFFF : l[31:0];
        end
        n_joints = n + 1;
      end
      if (fin) chain_open = 1'b0;
      return;
    end
    chain_open = 1'b0;
    n = n_joints;
    if (n < 2) begin
      r.idx = '0;
      r.x = n ? chain_x[0][31:0] : '0;
      r.y = n ? chain_y[0][31:0] : '0;
      r.z = n ? chain_z[0][31:0] : '0;
      r.st = STAT_SHORT;
      r.lst = 1'b1;
      due_add(r);
      return;
    end
    total = 0;
    for (int i = 0; i + 1 < n; i++) total += seg_len[i];
    rx = chain_x[0]; ry = chain_y[0]; rz = chain_z[0];
    if (longint'(vec_len(px - rx, py - ry, pz - rz)) >= total) begin
      for (int i = 0; i + 1 < n; i++) place_joint(i + 1, i, px, py, pz, i);
      st = STAT_STRETCHED;
    end else begin
      st = STAT_EXHAUSTED;
      for (int k = 0; k < int'(iter_lim); k++) begin
        chain_x[n-1] = px; chain_y[n-1] = py; chain_z[n-1] = pz;
        for (int i = n - 2; i >= 0; i--)
          place_joint(i, i + 1, chain_x[i], chain_y[i], chain_z[i], i);
        chain_x[0] = rx; chain_y[0] = ry; chain_z[0] = rz;
        for (int i = 0; i + 1 < n; i++)
          place_joint(i + 1, i, chain_x[i+1], chain_y[i+1], chain_z[i+1], i);
        if (vec_len(chain_x[n-1] - px, chain_y[n-1] - py, chain_z[n-1] - pz)
            < 34'(tol_lim)) begin
          st = STAT_CONVERGED;
          break;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.idx = i[JIDX_W-1:0];
      r.x = chain_x[i][31:0];
      r.y = chain_y[i][31:0];
      r.z = chain_z[i][31:0];
      r.st = st;
      r.lst = (i + 1 == n);
      due_add(r);
    end
  endfunction

  // offer one item, wait for the handshake, then predict
  task automatic send_item(logic cmd, int x, int y, int z, logic fin,
                           bit typed = 0, int ex = 0, int ey = 0, int ez = 0,
                           status_t est = STAT_SHORT);
    int         q0;
    joint_res_t r;
    if (!calm) while ($urandom_range(0, 99) < IDLE_PCT) @(negedge clk);
    item.cmd = cmd;
    item.pos_x = x; item.pos_y = y; item.pos_z = z;
    item.final_joint = fin;
    item.valid = 1'b1;
    do @(posedge clk); while (!item.ready);
    q0 = joints_due.size();
    solve_or_load(cmd, x, y, z, fin);
    if (typed) begin
      // expectation read straight off the row replaces the computed one
      while (joints_due.size() > q0) void'(joints_due.pop_back());
      r.idx = '0; r.x = ex; r.y = ey; r.z = ez; r.st = est; r.lst = 1'b1;
      due_add(r);
    end
    @(negedge clk);
    item.valid = 1'b0;
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == REG_MAX_ITER) iter_lim = val[7:0];
    else tol_lim = val[15:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // wait for every joint, then let a trailing load finish
  task automatic drain();
    while (joints_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic int rand_coord(int bits);
    if (bits >= 32) return int'($urandom);
    return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  // one chain with random content, followed by a few solves
  task automatic rand_chain(int nj_hi, output int sent);
    int  nj, bits, nsolve, pick;
    bit  closed;
    pick = $urandom_range(0, 19);
    if (pick == 0) nj = $urandom_range(0, 1);
    else if (pick == 1 && nj_hi >= NJ_MAX) nj = $urandom_range(14, 18); // around capacity, some over
    else nj = $urandom_range(2, nj_hi < 5 ? nj_hi : 5);
    bits = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(12, 22);
    closed = ($urandom_range(0, 5) != 0);
    sent = 0;
    for (int j = 0; j < nj; j++) begin
      send_item(CMD_LOAD, rand_coord(bits), rand_coord(bits), rand_coord(bits),
                (j == nj - 1) && closed);
      sent++;
    end
    // a stray load now and then, broken sequence
    if ($urandom_range(0, 9) == 0) begin
      send_item(CMD_LOAD, rand_coord(32), rand_coord(32), rand_coord(32), 1'($urandom));
      sent++;
    end
    nsolve = $urandom_range(1, 3);
    for (int s = 0; s < nsolve; s++) begin
      // targets span up to two bits wider so some fall out of reach
      send_item(CMD_SOLVE, rand_coord(bits == 32 ? 32 : bits + $urandom_range(0, 2)),
                rand_coord(bits == 32 ? 32 : bits + $urandom_range(0, 2)),
                rand_coord(bits == 32 ? 32 : bits + $urandom_range(0, 2)),
                1'($urandom));
      sent++;
    end
  endtask

  // result side: compare against the oldest expected joint
  always @(posedge clk) begin
    joint_res_t e;
    if (!rst && result.valid && result.ready) begin
      if (joints_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected joint idx %0d (%0d,%0d,%0d) status %0d last %0d",
                   result.joint_index, result.out_x, result.out_y, result.out_z,
                   result.status, result.last);
      end else begin
        e = joints_due.pop_front();
        if (result.joint_index !== e.idx || result.out_x !== e.x ||
            result.out_y !== e.y || result.out_z !== e.z ||
            result.status !== e.st || result.last !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("joint mismatch: exp idx %0d (%0d,%0d,%0d) st %0d last %0d, got idx %0d (%0d,%0d,%0d) st %0d last %0d",
                     e.idx, $signed(e.x), $signed(e.y), $signed(e.z), e.st, e.lst,
                     result.joint_index, result.out_x, result.out_y, result.out_z,
                     result.status, result.last);
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result.ready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end
      result.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready)) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  stim_row_t dir_rows[20];

  initial begin
    int sent, budget;
    logic [7:0]  ph_iter[5];
    logic [15:0] ph_tol[5];
    int          ph_items[5], ph_nj[5];

    item.valid = 1'b0; item.cmd = CMD_LOAD; item.final_joint = 1'b0;
    item.pos_x = '0; item.pos_y = '0; item.pos_z = '0;
    n_joints = 0; chain_open = 1'b0;
    iter_lim = MAX_ITER_RST; tol_lim = TOL_RST;

    dir_rows = '{
      // solve on an empty chain right after reset
      '{CMD_SOLVE, 5, 5, 5, 1'b0, 1'b1, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 32'h10000, 32'h20000, 32'h30000, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      // one joint chain comes back unchanged
      '{CMD_SOLVE, 9, 9, 9, 1'b0, 1'b1, 32'h10000, 32'h20000, 32'h30000, STAT_SHORT},
      '{CMD_LOAD, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 32'hA0000, 0, 0, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 32'hA0000, 32'hA0000, 0, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      // far target stretches, then reachable ones iterate
      '{CMD_SOLVE, 32'h640000, 0, 0, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h50000, 32'h50000, 32'h50000, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      // coordinate extremes, saturating segment length
      '{CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      // solve while the chain is still open
      '{CMD_LOAD, 1, -1, 1, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, -32'sh50000, 32'h30000, 32'h70000, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h20000, 32'h20000, 32'h20000, 1'b0, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h20000, -32'sh20000, 0, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_LOAD, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, STAT_SHORT},
      '{CMD_SOLVE, 32'h10000, 0, 0, 1'b0, 1'b1, 0, 0, 0, STAT_SHORT}
    };

    // register settings per random phase: count, tolerance, items, chain size
    ph_iter  = '{8'd10, 8'd0, 8'd255, 8'd1, 8'd3};
    ph_tol   = '{16'd7, 16'hFFFF, 16'd0, 16'hFFFF, 16'd100};
    ph_items = '{35, 20, 6, 30, 30};
    ph_nj    = '{NJ_MAX, NJ_MAX, 3, NJ_MAX, NJ_MAX};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].ez, dir_rows[i].est);

    for (int p = 0; p < 5; p++) begin
      drain();
      reg_write(REG_MAX_ITER, 32'(ph_iter[p]));
      reg_write(REG_TOL, 32'(ph_tol[p]));
      calm = (p == 3);    // a stretch with no idling at all
      budget = 0;
      while (budget < ph_items[p]) begin
        // stall the receiver mid-phase while items keep coming
        if (p == 0 && budget >= 10 && budget < 14) hold_req = 1'b1;
        rand_chain(ph_nj[p], sent);
        budget += sent;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
